// File: design/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MSWF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mswf assertion failed");

// Next-cycle implication, checked outside reset.
`define MSWF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mswf assertion failed");

`endif

// File: design/mswf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mswf_pkg;

  // Channel count and per-channel reset values
  localparam int CHANNELS          = 8;
  localparam int DEFAULT_WINDOW    = 16;
  localparam int DEFAULT_SMOOTHING = 128;

  // Index width for the per-channel state
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int CHAN_W   = 8;
  localparam int VAL_W    = 16;
  localparam int WEIGHT_W = 8;
  localparam int ACC_W    = VAL_W + WEIGHT_W;

  // Weight complement base: new sample gets (FULL_WEIGHT - s)
  localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 8'd255;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE     = 2'd0,
    CMD_SET_WINDOW = 2'd1,
    CMD_SET_SMOOTH = 2'd2
  } cmd_e;

  typedef enum logic {
    REG_MIN_VALUE = 1'b0,
    REG_MAX_VALUE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAN_W-1:0] channel;
    logic [VAL_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic [VAL_W-1:0] held_output;
    logic             channel_valid;
  } result_t;

  typedef struct packed {
    logic [VAL_W-1:0] min_value;
    logic [VAL_W-1:0] max_value;
  } cfg_t;

endpackage

`default_nettype wire

// File: design/mswf_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input item channel
interface mswf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  channel;
  logic [15:0] value;

  modport source (output valid, output cmd, output channel, output value, input ready);
  modport sink   (input valid, input cmd, input channel, input value, output ready);
endinterface

// Result item channel
interface mswf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] held_output;
  logic        channel_valid;

  modport source (output valid, output held_output, output channel_valid, input ready);
  modport sink   (input valid, input held_output, input channel_valid, output ready);
endinterface

`default_nettype wire

// File: design/mswf_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module mswf_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mswf_pkg::PADDR_W-1:0]  paddr,
  input  logic [mswf_pkg::PDATA_W-1:0]  pwdata,
  output logic [mswf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output mswf_pkg::cfg_t                cfg_o
);
  import mswf_pkg::*;

  logic             wr_en;
  logic             reg_idx;
  logic [VAL_W-1:0] min_q;
  logic [VAL_W-1:0] max_q;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  // Register writes on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MIN_VALUE: min_q <= pwdata[VAL_W-1:0];
        REG_MAX_VALUE: max_q <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Readback
  always_comb begin
    case (reg_idx)
      REG_MIN_VALUE: prdata = {{(PDATA_W-VAL_W){1'b0}}, min_q};
      REG_MAX_VALUE: prdata = {{(PDATA_W-VAL_W){1'b0}}, max_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.min_value = min_q;
  assign cfg_o.max_value = max_q;

endmodule

`default_nettype wire

// File: design/mswf_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none

module mswf_filter_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  mswf_pkg::item_t   item_i,
  input  mswf_pkg::cfg_t    cfg_i,
  output mswf_pkg::result_t result_o
);
  import mswf_pkg::*;

  // Per-channel state, one flop row per channel
  logic [VAL_W-1:0]    smooth_q [CHANNELS];
  logic [VAL_W-1:0]    held_q   [CHANNELS];
  logic [VAL_W-1:0]    win_q    [CHANNELS];
  logic [WEIGHT_W-1:0] weight_q [CHANNELS];

  logic                ch_valid;
  logic [CH_W-1:0]     idx;
  logic [WEIGHT_W-1:0] s;
  logic [ACC_W-1:0]    acc;
  logic [VAL_W-1:0]    temp;
  logic [VAL_W-1:0]    diff;
  logic [VAL_W-1:0]    held_cur;
  logic [VAL_W-1:0]    held_new;

  assign ch_valid = ({1'b0, item_i.channel} < (CHAN_W+1)'(CHANNELS));
  assign idx      = item_i.channel[CH_W-1:0];
  assign s        = weight_q[idx];
  assign held_cur = held_q[idx];

  // Exponential smoothing: (old*s + new*(255-s)) >> 8
  assign acc  = ACC_W'(smooth_q[idx]) * ACC_W'(s)
              + ACC_W'(item_i.value) * ACC_W'(FULL_WEIGHT - s);
  assign temp = acc[ACC_W-1:WEIGHT_W];
  assign diff = temp - held_cur;

  // Clamp, then hysteresis window (unsigned wrap: a drop of d counts as a rise of 65536-d)
  always_comb begin
    if (temp <= cfg_i.min_value) begin
      held_new = cfg_i.min_value;
    end else if (temp >= cfg_i.max_value) begin
      held_new = cfg_i.max_value;
    end else if (diff > win_q[idx]) begin
      held_new = temp;
    end else begin
      held_new = held_cur;
    end
  end

  // Result after this item
  always_comb begin
    result_o.channel_valid = ch_valid;
    result_o.held_output   = '0;
    if (ch_valid) begin
      case (item_i.cmd)
        CMD_SAMPLE: result_o.held_output = held_new;
        default:    result_o.held_output = held_cur;
      endcase
    end
  end

  // State update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        smooth_q[i] <= '0;
        held_q[i]   <= '0;
        win_q[i]    <= VAL_W'(DEFAULT_WINDOW);
        weight_q[i] <= WEIGHT_W'(DEFAULT_SMOOTHING);
      end
    end else if (en_i && ch_valid) begin
      case (item_i.cmd)
        CMD_SAMPLE: begin
          smooth_q[idx] <= temp;
          held_q[idx]   <= held_new;
        end
        CMD_SET_WINDOW: win_q[idx]    <= item_i.value;
        CMD_SET_SMOOTH: weight_q[idx] <= item_i.value[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/multichannel_smoothing_window_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Multichannel smoothing and hysteresis filter.
// in_i carries items (cmd, channel, value): a sample, a window write or a
// smoothing-weight write for one channel. out_o returns one result per item:
// the channel's held output after the item, and channel_valid. An item for a
// channel beyond the channel count changes nothing and returns 0 with
// channel_valid low.
// Pipeline: a transfer on in_i lands in the input register; once the result
// register is free, its result is loaded there and out_o.valid rises.
// While out_o does not stall, throughput is one item per cycle: the
// smoothing multiply-add, clamp and window compare fit between the input
// register and the result register, and per-channel state is written on the
// same edge, so back-to-back items to one channel see each other's updates.
// When out_o stalls, the result holds and one more item waits in the input
// register; in_i.ready then drops until the result is taken.
// Reset clears both registers' valid flags, sets min_value 0 and max_value 65535, and puts
// every channel at smoothed 0, held 0, default window and default weight.
// The user must write min_value/max_value over APB at 0x0 and 0x4 while idle; the block does not enforce this.
module multichannel_smoothing_window_filter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mswf_in_if.sink                       in_i,
  mswf_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mswf_pkg::PADDR_W-1:0]  paddr,
  input  logic [mswf_pkg::PDATA_W-1:0]  pwdata,
  output logic [mswf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import mswf_pkg::*;

  cfg_t    cfg;
  item_t   s1_q;
  logic    s1_valid_q;
  result_t res_d;
  result_t res_q;
  logic    res_valid_q;
  logic    res_free;
  logic    s1_fire;
  logic    in_fire;

  // Configuration registers
  mswf_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: the result register frees when empty or being taken
  assign res_free    = !res_valid_q || out_o.ready;
  assign s1_fire     = s1_valid_q && res_free;
  assign in_i.ready  = !s1_valid_q || res_free;
  assign in_fire     = in_i.valid && in_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.cmd     <= in_i.cmd;
      s1_q.channel <= in_i.channel;
      s1_q.value   <= in_i.value;
    end
  end

  // Filter datapath and per-channel state
  mswf_filter_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (s1_fire),
    .item_i   (s1_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.held_output   = res_q.held_output;
  assign out_o.channel_valid = res_q.channel_valid;

  // Checks
  `MSWF_ASSERT_NEXT(a_stage_to_result, clk_i, rst_ni, s1_fire, res_valid_q)
  `MSWF_ASSERT_NOW(a_ready_when_drained, clk_i, rst_ni, out_o.ready, in_i.ready)
  `MSWF_ASSERT_NOW(a_bad_channel_zero, clk_i, rst_ni, res_valid_q && !res_q.channel_valid, res_q.held_output == '0)

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import mswf_pkg::*;

  // Opcode with no action in the block; the result just reports the held output
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int HOLD_OFF_CYCLES = 40;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PHASE_ITEMS     = 220;
  localparam int PHASES          = 6;

  // Expected-output predictor and result checker
  class filter_scoreboard;
    logic [VAL_W-1:0]    smoothed [CHANNELS];
    logic [VAL_W-1:0]    held     [CHANNELS];
    logic [VAL_W-1:0]    window   [CHANNELS];
    logic [WEIGHT_W-1:0] weight   [CHANNELS];
    logic [VAL_W-1:0]    clamp_lo;
    logic [VAL_W-1:0]    clamp_hi;
    result_t             expected_outputs [$];
    int unsigned         errors;

    function new();
      clamp_lo = '0;
      clamp_hi = '1;
      errors   = 0;
      for (int i = 0; i < CHANNELS; i++) begin
        smoothed[i] = '0;
        held[i]     = '0;
        window[i]   = VAL_W'(DEFAULT_WINDOW);
        weight[i]   = WEIGHT_W'(DEFAULT_SMOOTHING);
      end
    endfunction

    function void set_reg(reg_idx_e idx, logic [VAL_W-1:0] v);
      if (idx == REG_MIN_VALUE) begin
        clamp_lo = v;
      end else begin
        clamp_hi = v;
      end
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    // Update the channel state for one accepted transfer and queue its output
    function void predict_item(item_t it);
      logic [ACC_W-1:0] acc;
      logic [VAL_W-1:0] avg;
      logic [VAL_W-1:0] rise;
      logic [CH_W-1:0]  idx;
      result_t          r;
      if (int'(it.channel) >= CHANNELS) begin
        r.held_output   = '0;
        r.channel_valid = 1'b0;
      end else begin
        idx = it.channel[CH_W-1:0];
        case (it.cmd)
          CMD_SAMPLE: begin
            acc = ACC_W'(smoothed[idx]) * ACC_W'(weight[idx])
                + ACC_W'(it.value) * ACC_W'(FULL_WEIGHT - weight[idx]);
            avg = acc[ACC_W-1:WEIGHT_W];
            smoothed[idx] = avg;
            // wraps, so a drop of d looks like a rise of 65536-d
            rise = avg - held[idx];
            if (avg <= clamp_lo) begin
              held[idx] = clamp_lo;
            end else if (avg >= clamp_hi) begin
              held[idx] = clamp_hi;
            end else if (rise > window[idx]) begin
              held[idx] = avg;
            end
          end
          CMD_SET_WINDOW: window[idx] = it.value;
          CMD_SET_SMOOTH: weight[idx] = it.value[WEIGHT_W-1:0];
          default: ;
        endcase
        r.held_output   = held[idx];
        r.channel_valid = 1'b1;
      end
      expected_outputs.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("tb: mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(logic [VAL_W-1:0] held_out, logic ch_valid);
      result_t exp_r;
      if (expected_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected result held_output=%0d channel_valid=%0b",
                                  held_out, ch_valid));
        return;
      end
      exp_r = expected_outputs.pop_front();
      if (held_out !== exp_r.held_output) begin
        report_mismatch($sformatf("held_output %0d, expected %0d",
                                  held_out, exp_r.held_output));
      end
      if (ch_valid !== exp_r.channel_valid) begin
        report_mismatch($sformatf("channel_valid %0b, expected %0b",
                                  ch_valid, exp_r.channel_valid));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  mswf_in_if  in_if ();
  mswf_out_if out_if ();

  multichannel_smoothing_window_filter_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  filter_scoreboard sb = new();

  int unsigned      idle_pct;
  bit               hold_off_req;
  int unsigned      quiet_cycles;
  logic [VAL_W-1:0] last_sample [CHANNELS];

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: note input transfers, check output transfers, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        sb.predict_item('{cmd: in_if.cmd, channel: in_if.channel, value: in_if.value});
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.held_output, out_if.channel_valid);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Result receiver: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        stall_left   = $urandom_range(0, 2);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic item_t mk_item(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] ch,
                                    logic [VAL_W-1:0] v);
    item_t it;
    it.cmd     = cmd;
    it.channel = ch;
    it.value   = v;
    return it;
  endfunction

  // Mostly valid channels and samples; samples often step near the last one
  function automatic item_t rand_item();
    item_t       it;
    int unsigned pick;
    int unsigned ch;
    if ($urandom_range(0, 99) < 85) begin
      ch = $urandom_range(0, CHANNELS - 1);
    end else begin
      ch = $urandom_range(CHANNELS, 255);
    end
    it.channel = CHAN_W'(ch);
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      it.cmd = CMD_SAMPLE;
      if (ch < CHANNELS && $urandom_range(0, 1) == 1) begin
        it.value = last_sample[ch] + VAL_W'($urandom_range(0, 511)) - VAL_W'(256);
      end else begin
        it.value = VAL_W'($urandom_range(0, 65535));
      end
      if (ch < CHANNELS) last_sample[ch] = it.value;
    end else if (pick < 84) begin
      it.cmd = CMD_SET_WINDOW;
      if ($urandom_range(0, 3) != 0) begin
        it.value = VAL_W'($urandom_range(0, 64));
      end else begin
        it.value = VAL_W'($urandom_range(0, 65535));
      end
    end else if (pick < 96) begin
      it.cmd   = CMD_SET_SMOOTH;
      it.value = VAL_W'($urandom_range(0, 65535));
    end else begin
      it.cmd   = CMD_UNUSED;
      it.value = VAL_W'($urandom_range(0, 65535));
    end
    return it;
  endfunction

  // Offer one item after an optional gap; returns once it is transferred
  task automatic send_item(item_t it);
    if ($urandom_range(0, 99) < idle_pct) begin
      repeat ($urandom_range(1, 3)) @(negedge clk) in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid   <= 1'b1;
    in_if.cmd     <= it.cmd;
    in_if.channel <= it.channel;
    in_if.value   <= it.value;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [VAL_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= PDATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stop offering, wait for every queued output, then wait out DRAIN_CYCLES
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.cmd     = '0;
    in_if.channel = '0;
    in_if.value   = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    idle_pct      = 20;
    hold_off_req  = 1'b0;
    quiet_cycles  = 0;
    for (int i = 0; i < CHANNELS; i++) last_sample[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: full-scale samples, window and weight extremes,
    // the unused opcode and out-of-range channels
    send_item(mk_item(CMD_SAMPLE, 8'd0, 16'hFFFF));
    send_item(mk_item(CMD_SAMPLE, 8'd0, 16'h0000));
    send_item(mk_item(CMD_UNUSED, 8'd0, 16'h1234));
    send_item(mk_item(CMD_SET_WINDOW, 8'd1, 16'hFFFF));
    send_item(mk_item(CMD_SAMPLE, 8'd1, 16'd1000));
    send_item(mk_item(CMD_SET_WINDOW, 8'd1, 16'h0000));
    send_item(mk_item(CMD_SAMPLE, 8'd1, 16'd1000));
    send_item(mk_item(CMD_SET_SMOOTH, 8'd2, 16'h0000));
    send_item(mk_item(CMD_SAMPLE, 8'd2, 16'hFFFF));
    send_item(mk_item(CMD_SET_SMOOTH, 8'd2, 16'hFFFF));
    send_item(mk_item(CMD_SAMPLE, 8'd2, 16'h0000));
    send_item(mk_item(CMD_SET_SMOOTH, 8'd7, 16'hAB00));
    send_item(mk_item(CMD_SAMPLE, 8'd7, 16'h0000));
    send_item(mk_item(CMD_SAMPLE, 8'd7, 16'h5555));
    send_item(mk_item(CMD_SAMPLE, 8'd7, 16'h5560));
    send_item(mk_item(CMD_SAMPLE, 8'd8, 16'hFFFF));
    send_item(mk_item(CMD_SET_WINDOW, 8'd255, 16'h0000));
    send_item(mk_item(CMD_SET_SMOOTH, 8'd128, 16'h0000));
    send_item(mk_item(CMD_UNUSED, 8'd200, 16'hFFFF));
    send_item(mk_item(CMD_SAMPLE, 8'd3, 16'hAAAA));
    send_item(mk_item(CMD_SAMPLE, 8'd4, 16'h5555));
    send_item(mk_item(CMD_UNUSED, 8'd9, 16'h0000));

    // Random phases, each under its own clamp setting
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin lo = 16'd1000;  hi = 16'd60000; idle_pct = 20; end
        1: begin lo = 16'hFFFF;  hi = 16'h0000;  idle_pct = 30; end
        2: begin lo = 16'h0000;  hi = 16'h0000;  idle_pct = 0;  end
        3: begin lo = 16'hFFFF;  hi = 16'hFFFF;  idle_pct = 15; end
        4: begin
          lo = VAL_W'($urandom_range(0, 32767));
          hi = VAL_W'($urandom_range(32768, 65535));
          idle_pct = 25;
        end
        default: begin lo = 16'h0000; hi = 16'hFFFF; idle_pct = 0; end
      endcase
      apb_write(REG_MIN_VALUE, lo);
      apb_write(REG_MAX_VALUE, hi);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off to back the block up into its input
        if (p == 1 && n == 60) hold_off_req = 1'b1;
        send_item(rand_item());
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
